// ----- sv/cwrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 word deframer package
// Shared types, constants and the CRC-8 byte update (poly 0x31, MSB first).
// ----------------------------------------------------------------------------
package cwrd_pkg;

   // CRC-8 polynomial and seed value
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Reset value of the words-per-response register
   localparam logic [2:0] RESPONSE_WORDS_RESET = 3'd3;

   // Byte position within one word
   typedef enum logic [1:0] {
      PHASE_HIGH = 2'd0,
      PHASE_LOW  = 2'd1,
      PHASE_CRC  = 2'd2
   } phase_type;

   // Fold one byte into the CRC, MSB first
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ----- sv/cwrd_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 word deframer channels
// Valid/ready channels for received bytes, rebuilt words and the register.
// ----------------------------------------------------------------------------

// Received byte stream
interface cwrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       start_of_response;

   modport source (output valid, output rx_byte, output start_of_response, input ready);
   modport sink   (input valid, input rx_byte, input start_of_response, output ready);
endinterface

// Rebuilt words with CRC status
interface cwrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] word_value;
   logic        crc_ok;
   logic        response_ok;
   logic        last_word;

   modport source (output valid, output word_value, output crc_ok, output response_ok,
                   output last_word, input ready);
   modport sink   (input valid, input word_value, input crc_ok, input response_ok,
                   input last_word, output ready);
endinterface

// Words-per-response register write
interface cwrd_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] response_words;

   modport source (output valid, output response_words, input ready);
   modport sink   (input valid, input response_words, output ready);
endinterface

// ----- sv/crc8_word_response_deframer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 word response deframer
// Rebuilds 16-bit words from high, low and CRC bytes and checks each CRC.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and returns one word after every third
// byte of a word (high, low, CRC-8 with poly 0x31 and seed 0xFF). The result
// appears in the output register in the cycle after the CRC byte transfer; a
// byte is taken in every cycle as long as the output register is empty or
// being drained, so the rate is one byte per cycle, set by the single
// register stage that holds the framing state. A start flag drops any
// partial word and begins a new response. The csr write sets the words per
// response (0 acts as 1, values above MAX_WORDS act as MAX_WORDS) and is
// always accepted.
module crc8_word_response_deframer_unit #(
   parameter int MAX_WORDS = 4
) (
   input  logic        clock,
   input  logic        reset,
   cwrd_req_if.sink    req_chan,
   cwrd_rsp_if.source  rsp_chan,
   cwrd_csr_if.sink    csr_chan
);

   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam int CMP_W = ((CNT_W > 3) ? CNT_W : 3) + 1;
   localparam logic [CMP_W-1:0] MAX_WORDS_CMP = CMP_W'(MAX_WORDS);

   // framing state
   cwrd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          crc_ff, crc_in;
   logic [7:0]          high_ff, high_in;
   logic [7:0]          low_ff, low_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                good_ff, good_in;
   logic [2:0]          response_words_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] word_ff, word_in;
   logic        crc_ok_ff, crc_ok_in;
   logic        resp_ok_ff, resp_ok_in;
   logic        last_ff, last_in;

   logic                accept;
   logic                emit;
   cwrd_pkg::phase_type phase_eff;
   logic [7:0]          crc_eff;
   logic [CNT_W-1:0]    count_eff;
   logic                good_eff;
   logic [CMP_W-1:0]    words_exp;
   logic                ok;
   logic                last;

   // take a byte while the result register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // clamp the configured word count to 1..MAX_WORDS
   always_comb begin
      words_exp = CMP_W'(response_words_ff);
      if (words_exp == '0) begin
         words_exp = CMP_W'(1);
      end
      if (words_exp > MAX_WORDS_CMP) begin
         words_exp = MAX_WORDS_CMP;
      end
   end

   // apply the start flag before decoding the byte position
   always_comb begin
      if (req_chan.start_of_response) begin
         phase_eff = cwrd_pkg::PHASE_HIGH;
         crc_eff   = cwrd_pkg::CRC_INIT;
         count_eff = '0;
         good_eff  = 1'b1;
      end else begin
         phase_eff = phase_ff;
         crc_eff   = crc_ff;
         count_eff = count_ff;
         good_eff  = good_ff;
      end
   end

   // next framing state and result
   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      count_in  = count_ff;
      good_in   = good_ff;
      emit      = 1'b0;
      ok        = (crc_eff == req_chan.rx_byte);
      last      = (CMP_W'(count_eff) + CMP_W'(1)) >= words_exp;
      if (accept) begin
         count_in = count_eff;
         good_in  = good_eff;
         unique case (phase_eff)
            cwrd_pkg::PHASE_LOW: begin
               low_in   = req_chan.rx_byte;
               crc_in   = cwrd_pkg::crc8_feed(crc_eff, req_chan.rx_byte);
               phase_in = cwrd_pkg::PHASE_CRC;
            end
            cwrd_pkg::PHASE_CRC: begin
               emit     = 1'b1;
               crc_in   = cwrd_pkg::CRC_INIT;
               phase_in = cwrd_pkg::PHASE_HIGH;
               if (last) begin
                  count_in = '0;
                  good_in  = 1'b1;
               end else begin
                  count_in = count_eff + CNT_W'(1);
                  good_in  = good_eff && ok;
               end
            end
            default: begin
               high_in  = req_chan.rx_byte;
               crc_in   = cwrd_pkg::crc8_feed(cwrd_pkg::CRC_INIT, req_chan.rx_byte);
               phase_in = cwrd_pkg::PHASE_LOW;
            end
         endcase
      end
   end

   // load the result register on a word, drop it once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      word_in      = word_ff;
      crc_ok_in    = crc_ok_ff;
      resp_ok_in   = resp_ok_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         word_in      = {high_ff, low_ff};
         crc_ok_in    = ok;
         resp_ok_in   = good_eff && ok;
         last_in      = last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= cwrd_pkg::PHASE_HIGH;
         crc_ff            <= cwrd_pkg::CRC_INIT;
         count_ff          <= '0;
         good_ff           <= 1'b1;
         rsp_valid_ff      <= 1'b0;
         response_words_ff <= cwrd_pkg::RESPONSE_WORDS_RESET;
      end else begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            response_words_ff <= csr_chan.response_words;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      high_ff    <= high_in;
      low_ff     <= low_in;
      word_ff    <= word_in;
      crc_ok_ff  <= crc_ok_in;
      resp_ok_ff <= resp_ok_in;
      last_ff    <= last_in;
   end

   // drive the result channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.word_value  = word_ff;
   assign rsp_chan.crc_ok      = crc_ok_ff;
   assign rsp_chan.response_ok = resp_ok_ff;
   assign rsp_chan.last_word   = last_ff;

endmodule

// ----- tb/sv/crc8_word_response_deframer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 word response deframer testbench
// Drives received bytes with random gaps and result back-pressure, tracks the
// word framing and CRC-8 in a local model and checks every returned word.
// ----------------------------------------------------------------------------
module crc8_word_response_deframer_unit_tb;

   localparam int MAX_WORDS   = 4;
   localparam int ITEM_TARGET = 650;
   localparam int IDLE_PCT    = 7;

   typedef struct packed {
      logic [15:0] value;
      logic        crc_ok;
      logic        response_ok;
      logic        last_word;
   } word_result_type;

   logic clock;
   logic reset;

   cwrd_req_if req_bus ();
   cwrd_rsp_if rsp_bus ();
   cwrd_csr_if csr_bus ();

   crc8_word_response_deframer_unit #(
      .MAX_WORDS(MAX_WORDS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // Local copy of the framing state
   cwrd_pkg::phase_type frame_phase;
   logic [7:0]          crc_run;
   logic [7:0]          high_hold;
   logic [7:0]          low_hold;
   int                  words_seen;
   logic                good_so_far;
   logic [2:0]          words_reg;

   word_result_type pending_words[$];

   // Stimulus side copy of the register and run statistics
   logic [2:0]   stim_words;
   bit           steady_flow;
   int           bytes_sent;
   int           words_checked;
   int           bad_crc_words;
   int           last_words;
   int           csr_writes;
   int           mismatch_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Timeout with %0d words still pending", pending_words.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // CRC-8, poly 0x31, one data bit at a time, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         if (r[7] ^ data[i]) begin
            r = {r[6:0], 1'b0} ^ cwrd_pkg::CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Effective words per response: 0 acts as 1, above MAX_WORDS acts as MAX_WORDS
   function automatic int clamp_words(input logic [2:0] w);
      if (w == 3'd0) begin
         return 1;
      end
      if (int'(w) > MAX_WORDS) begin
         return MAX_WORDS;
      end
      return int'(w);
   endfunction

   // Advance the framing model by one received byte, queue any finished word
   function automatic void track_byte(input logic [7:0] b, input logic sor);
      word_result_type w;
      logic            ok;
      if (sor) begin
         frame_phase = cwrd_pkg::PHASE_HIGH;
         crc_run     = cwrd_pkg::CRC_INIT;
         words_seen  = 0;
         good_so_far = 1'b1;
      end
      case (frame_phase)
         cwrd_pkg::PHASE_LOW: begin
            low_hold    = b;
            crc_run     = crc8_step(crc_run, b);
            frame_phase = cwrd_pkg::PHASE_CRC;
         end
         cwrd_pkg::PHASE_CRC: begin
            ok            = (crc_run == b);
            good_so_far   = good_so_far & ok;
            w.value       = {high_hold, low_hold};
            w.crc_ok      = ok;
            w.response_ok = good_so_far;
            w.last_word   = (words_seen + 1) >= clamp_words(words_reg);
            pending_words.push_back(w);
            if (w.last_word) begin
               words_seen  = 0;
               good_so_far = 1'b1;
            end else begin
               words_seen++;
            end
            frame_phase = cwrd_pkg::PHASE_HIGH;
            crc_run     = cwrd_pkg::CRC_INIT;
         end
         default: begin
            high_hold   = b;
            crc_run     = crc8_step(cwrd_pkg::CRC_INIT, b);
            frame_phase = cwrd_pkg::PHASE_LOW;
         end
      endcase
   endfunction

   function automatic void report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
   endfunction

   // Watch all three channels at the rising edge
   always @(posedge clock) begin
      word_result_type got;
      word_result_type want;
      if (reset) begin
         frame_phase = cwrd_pkg::PHASE_HIGH;
         crc_run     = cwrd_pkg::CRC_INIT;
         high_hold   = 8'h00;
         low_hold    = 8'h00;
         words_seen  = 0;
         good_so_far = 1'b1;
         words_reg   = cwrd_pkg::RESPONSE_WORDS_RESET;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            words_reg = csr_bus.response_words;
         end
         if (req_bus.valid && req_bus.ready) begin
            track_byte(req_bus.rx_byte, req_bus.start_of_response);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.value       = rsp_bus.word_value;
            got.crc_ok      = rsp_bus.crc_ok;
            got.response_ok = rsp_bus.response_ok;
            got.last_word   = rsp_bus.last_word;
            words_checked++;
            if (pending_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h crc_ok %b resp_ok %b last %b",
                                         got.value, got.crc_ok, got.response_ok,
                                         got.last_word));
            end else begin
               want = pending_words.pop_front();
               if (!want.crc_ok) bad_crc_words++;
               if (want.last_word) last_words++;
               if (got !== want) begin
                  report_mismatch($sformatf(
                     "word exp %h/%b/%b/%b got %h/%b/%b/%b (value/crc_ok/resp_ok/last)",
                     want.value, want.crc_ok, want.response_ok, want.last_word,
                     got.value, got.crc_ok, got.response_ok, got.last_word));
               end
            end
         end
      end
   end

   // Result back-pressure
   always @(negedge clock) begin
      if (steady_flow) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Send one byte; returns at the falling edge after the transfer with valid still high
   task automatic send_byte(input logic [7:0] b, input logic sor);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.rx_byte           <= b;
      req_bus.start_of_response <= sor;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Send high, low and CRC bytes of one word, optionally with a broken CRC
   task automatic send_word(input logic [15:0] value, input logic sor, input bit corrupt);
      logic [7:0] crc;
      crc = crc8_step(crc8_step(cwrd_pkg::CRC_INIT, value[15:8]), value[7:0]);
      if (corrupt) begin
         crc = crc ^ 8'($urandom_range(1, 255));
      end
      send_byte(value[15:8], sor);
      send_byte(value[7:0], 1'b0);
      send_byte(crc, 1'b0);
   endtask

   // Drop valid and hold until every queued word has come back
   task automatic wait_words_drained();
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write the words-per-response register; call only when drained
   task automatic write_words(input logic [2:0] w);
      csr_bus.valid          <= 1'b1;
      csr_bus.response_words <= w;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      stim_words = w;
      csr_writes++;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Reset default of three words, extreme values, one bad CRC in the middle
   task automatic test_default_framing();
      send_word(16'h0000, 1'b1, 1'b0);
      send_word(16'hFFFF, 1'b0, 1'b1);
      send_word(16'h8001, 1'b0, 1'b0);
   endtask

   // Partial word without a start flag, then resync on a start flag
   task automatic test_resync_mid_word();
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_word(16'hABCD, 1'b1, 1'b0);
      wait_words_drained();
   endtask

   // Shrink the count to no more than the words already received, then clamp both ends
   task automatic test_count_changes();
      write_words(3'd1);
      send_word(16'h5A5A, 1'b0, 1'b0);
      wait_words_drained();
      write_words(3'd0);
      send_word(16'h00FF, 1'b1, 1'b0);
      wait_words_drained();
      write_words(3'd7);
      send_word(16'hFF00, 1'b1, 1'b0);
      send_word(16'h7FFE, 1'b0, 1'b0);
      wait_words_drained();
   endtask

   // Mostly whole responses with random content, plus register writes, noise and cut-off words
   task automatic test_random_traffic();
      int kind;
      int n;
      logic sor;
      while (bytes_sent < ITEM_TARGET) begin
         steady_flow = (bytes_sent >= 300 && bytes_sent < 420);
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            wait_words_drained();
            write_words(3'($urandom_range(0, 7)));
         end else if (kind < 82) begin
            sor = ($urandom_range(0, 99) < 90);
            n   = clamp_words(stim_words);
            for (int i = 0; i < n; i++) begin
               send_word(pick_word(), sor && (i == 0), $urandom_range(0, 99) < 12);
            end
         end else if (kind < 92) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 30);
            end
         end else begin
            n = $urandom_range(1, 2);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            if (n == 2) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      steady_flow = 1'b0;
      wait_words_drained();
   endtask

   // Main sequence
   initial begin
      reset                     = 1'b1;
      req_bus.valid             = 1'b0;
      req_bus.rx_byte           = 8'h00;
      req_bus.start_of_response = 1'b0;
      csr_bus.valid             = 1'b0;
      csr_bus.response_words    = 3'd0;
      rsp_bus.ready             = 1'b0;
      stim_words                = cwrd_pkg::RESPONSE_WORDS_RESET;
      steady_flow               = 1'b0;
      bytes_sent                = 0;
      words_checked             = 0;
      bad_crc_words             = 0;
      last_words                = 0;
      csr_writes                = 0;
      mismatch_count            = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_framing();
      test_resync_mid_word();
      test_count_changes();
      test_random_traffic();
      repeat (10) @(negedge clock);

      $display("Covered %0d bytes, %0d words checked (%0d bad CRC, %0d response ends)",
               bytes_sent, words_checked, bad_crc_words, last_words);
      $display("Register written %0d times; %0d mismatches", csr_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/cwrd_pkg.sv
sv/cwrd_channels.sv
sv/crc8_word_response_deframer_unit.sv
tb/sv/crc8_word_response_deframer_unit_tb.sv
